// ===== hw/rtl/mbf_pkg.sv =====
package mbf_pkg;

    // Defaults
    localparam int unsigned QUEUE_DEPTH     = 2;
    localparam logic [7:0]  CHUNK_LEN_RESET = 8'd128;
    localparam logic [7:0]  CHUNK_LEN_MIN   = 8'd2;

    // MIDI byte classes
    localparam logic [7:0] STATUS_MIN   = 8'h80;
    localparam logic [7:0] PROG_MIN     = 8'hC0;
    localparam logic [7:0] PRESS_MAX    = 8'hDF;
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] MTC_QFRAME   = 8'hF1;
    localparam logic [7:0] SONG_POS     = 8'hF2;
    localparam logic [7:0] SONG_SEL     = 8'hF3;
    localparam logic [7:0] SYSEX_END    = 8'hF7;
    localparam logic [7:0] REALTIME_MIN = 8'hF8;

    typedef enum logic [1:0] {
        KIND_SHORT      = 2'd0,
        KIND_SYSEX_BYTE = 2'd1,
        KIND_CHUNK_END  = 2'd2
    } kind_t;

    // One result word
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  count;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic        trunc;
    } result_t;

    // Front-to-back command: one or two results caused by one input word
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } cmd_t;

    function automatic result_t make_result(
        input kind_t      kind,
        input logic [1:0] count,
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic       trunc
    );
        result_t r;
        r.kind  = kind;
        r.count = count;
        r.byte0 = b0;
        r.byte1 = b1;
        r.byte2 = b2;
        r.trunc = trunc;
        return r;
    endfunction

endpackage

// ===== hw/rtl/mbf_front.sv =====
module mbf_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [7:0]      cfg_wr_data,
    input  logic            in_accept,
    input  logic [7:0]      in_byte,
    output logic            cmd_valid,
    output mbf_pkg::cmd_t   cmd
);

    logic [7:0]      chunk_len_reg;
    logic [7:0]      remain_reg,   remain_next;
    logic [7:0]      status_reg,   status_next;
    logic [7:0]      run_len_reg,  run_len_next;
    logic [2:0][7:0] held_reg,     held_next;
    logic [1:0]      held_cnt_reg, held_cnt_next;

    logic [7:0]        eff_len;
    logic [1:0]        n_res;
    mbf_pkg::result_t  res0, res1;

    // Chunk lengths below two act as two
    assign eff_len = (chunk_len_reg < mbf_pkg::CHUNK_LEN_MIN) ? mbf_pkg::CHUNK_LEN_MIN
                                                              : chunk_len_reg;

    // Classify the byte, update parser state, build up to two results
    always_comb begin
        logic              stop;
        logic              flush;
        mbf_pkg::result_t  item;
        remain_next   = remain_reg;
        status_next   = status_reg;
        run_len_next  = run_len_reg;
        held_next     = held_reg;
        held_cnt_next = held_cnt_reg;
        n_res         = 2'd0;
        res0          = '0;
        res1          = '0;
        stop          = 1'b0;
        flush         = 1'b0;
        item          = '0;

        // Byte arriving inside a pending message or chunk
        if (remain_reg != 8'd0) begin
            if (in_byte < mbf_pkg::REALTIME_MIN) begin
                if (in_byte >= mbf_pkg::STATUS_MIN) begin
                    if (status_reg == mbf_pkg::SYSEX_START &&
                        in_byte == mbf_pkg::SYSEX_END) begin
                        res0 = mbf_pkg::make_result(mbf_pkg::KIND_SYSEX_BYTE, 2'd1,
                                                    in_byte, 8'd0, 8'd0, 1'b0);
                        res1 = mbf_pkg::make_result(mbf_pkg::KIND_CHUNK_END, 2'd0,
                                                    8'd0, 8'd0, 8'd0, 1'b0);
                        n_res       = 2'd2;
                        status_next = 8'd0;
                        remain_next = 8'd0;
                        stop        = 1'b1;
                    end else begin
                        flush = 1'b1;
                    end
                end
            end else if (status_reg != mbf_pkg::SYSEX_START) begin
                // real-time inside a short message: send now, keep the message
                res0  = mbf_pkg::make_result(mbf_pkg::KIND_SHORT, 2'd1,
                                             in_byte, 8'd0, 8'd0, 1'b0);
                n_res = 2'd1;
                stop  = 1'b1;
            end else begin
                flush = 1'b1;
            end
        end

        // Cut the pending message or chunk short
        if (flush) begin
            if (status_reg == mbf_pkg::SYSEX_START) begin
                res0 = mbf_pkg::make_result(mbf_pkg::KIND_CHUNK_END, 2'd0,
                                            8'd0, 8'd0, 8'd0, 1'b1);
            end else begin
                res0 = mbf_pkg::make_result(mbf_pkg::KIND_SHORT, held_cnt_reg,
                                            held_reg[0], held_reg[1], held_reg[2], 1'b1);
            end
            held_next     = '0;
            held_cnt_next = 2'd0;
            n_res         = 2'd1;
            remain_next   = 8'd0;
        end

        // Start of a new message
        if (!stop && remain_next == 8'd0) begin
            if (in_byte >= mbf_pkg::SYSEX_START) begin
                if (in_byte < mbf_pkg::REALTIME_MIN) begin
                    status_next  = 8'd0;
                    run_len_next = 8'd0;
                end
                if (in_byte == mbf_pkg::SYSEX_START) begin
                    remain_next  = eff_len;
                    status_next  = mbf_pkg::SYSEX_START;
                    run_len_next = eff_len;
                end else if (in_byte == mbf_pkg::MTC_QFRAME ||
                             in_byte == mbf_pkg::SONG_SEL) begin
                    remain_next = 8'd2;
                end else if (in_byte == mbf_pkg::SONG_POS) begin
                    remain_next = 8'd3;
                end else begin
                    remain_next = 8'd1;
                end
            end else if (in_byte >= mbf_pkg::STATUS_MIN) begin
                status_next  = in_byte;
                remain_next  = (in_byte < mbf_pkg::PROG_MIN || in_byte > mbf_pkg::PRESS_MAX)
                               ? 8'd3 : 8'd2;
                run_len_next = remain_next;
            end else if (status_next != 8'd0) begin
                // running status: data only
                remain_next = (run_len_next < 8'd2) ? 8'd1 : run_len_next - 8'd1;
            end else begin
                // data with no running status is dropped
                stop = 1'b1;
            end
        end

        // Consume the byte
        if (!stop) begin
            remain_next = remain_next - 8'd1;
            if (status_next == mbf_pkg::SYSEX_START && in_byte < mbf_pkg::REALTIME_MIN) begin
                item = mbf_pkg::make_result(mbf_pkg::KIND_SYSEX_BYTE, 2'd1,
                                            in_byte, 8'd0, 8'd0, 1'b0);
                if (n_res == 2'd0) res0 = item;
                else               res1 = item;
                n_res = n_res + 2'd1;
                if (remain_next == 8'd0) begin
                    item = mbf_pkg::make_result(mbf_pkg::KIND_CHUNK_END, 2'd0,
                                                8'd0, 8'd0, 8'd0, 1'b0);
                    if (n_res == 2'd0) res0 = item;
                    else               res1 = item;
                    n_res = n_res + 2'd1;
                end
            end else begin
                if (held_cnt_next != 2'd3) begin
                    held_next[held_cnt_next] = in_byte;
                    held_cnt_next            = held_cnt_next + 2'd1;
                end
                if (remain_next == 8'd0) begin
                    item = mbf_pkg::make_result(mbf_pkg::KIND_SHORT, held_cnt_next,
                                                held_next[0], held_next[1], held_next[2],
                                                1'b0);
                    if (n_res == 2'd0) res0 = item;
                    else               res1 = item;
                    n_res         = n_res + 2'd1;
                    held_next     = '0;
                    held_cnt_next = 2'd0;
                end
            end
        end
    end

    assign cmd_valid  = in_accept && (n_res != 2'd0);
    assign cmd.two    = (n_res == 2'd2);
    assign cmd.first  = res0;
    assign cmd.second = res1;

    // Parser state and config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_len_reg <= mbf_pkg::CHUNK_LEN_RESET;
            remain_reg    <= 8'd0;
            status_reg    <= 8'd0;
            run_len_reg   <= 8'd1;
            held_reg      <= '0;
            held_cnt_reg  <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                chunk_len_reg <= cfg_wr_data;
            end
            if (in_accept) begin
                remain_reg   <= remain_next;
                status_reg   <= status_next;
                run_len_reg  <= run_len_next;
                held_reg     <= held_next;
                held_cnt_reg <= held_cnt_next;
            end
        end
    end

    // Nothing is held once no message is pending
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (remain_reg == 8'd0) |-> (held_cnt_reg == 2'd0))
        else $error("held bytes left with no pending message");

    // Held bytes only build up outside sysex
    a_sysex_no_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (status_reg == mbf_pkg::SYSEX_START) |-> (held_cnt_reg == 2'd0))
        else $error("held bytes during sysex");

endmodule

// ===== hw/rtl/mbf_queue.sv =====
module mbf_queue #(
    parameter int unsigned DEPTH = mbf_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mbf_pkg::cmd_t   push_data,
    output logic            full,
    input  logic            pop,
    output mbf_pkg::cmd_t   pop_data,
    output logic            not_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    mbf_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    // Pointer wrap and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && count_reg == FULL_CNT))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && count_reg == '0))
        else $error("queue read while empty");

endmodule

// ===== hw/rtl/mbf_back.sv =====
module mbf_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  mbf_pkg::cmd_t      q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output mbf_pkg::result_t   out_res,
    output logic               out_last
);

    logic              out_valid_reg, out_valid_next;
    mbf_pkg::result_t  out_res_reg,   out_res_next;
    logic              out_last_reg,  out_last_next;
    logic              pend_reg,      pend_next;
    mbf_pkg::result_t  pend_res_reg,  pend_res_next;
    logic              out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = out_free && !pend_reg && q_valid;

    // Output register: second result of a pair goes first, then the queue head
    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_last_next  = out_last_reg;
        pend_next      = pend_reg;
        pend_res_next  = pend_res_reg;
        if (out_free) begin
            if (pend_reg) begin
                out_valid_next = 1'b1;
                out_res_next   = pend_res_reg;
                out_last_next  = 1'b1;
                pend_next      = 1'b0;
            end else if (q_valid) begin
                out_valid_next = 1'b1;
                out_res_next   = q_data.first;
                out_last_next  = !q_data.two;
                pend_next      = q_data.two;
                pend_res_next  = q_data.second;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
        pend_res_reg <= pend_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

    a_pend_has_first: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (out_valid_reg && !out_last_reg))
        else $error("second result pending without a non-final first");

    a_pop_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> out_valid_reg)
        else $error("popped command not loaded");

endmodule

// ===== hw/rtl/midi_byte_stream_message_framer_top.sv =====
// An accepted input word goes through the command queue and the output register to
// m_tvalid. One input word per cycle while the queue is not full; a word with two
// results sends them in turn, as the output register sends one result per cycle.
// A 2-entry command queue lets input keep flowing while the output stalls.
// Reset: synchronous, active-low aresetn; no running status, no pending message,
// chunk length 128, queue and output register empty.
module midi_byte_stream_message_framer_top #(
    parameter int unsigned QUEUE_DEPTH = mbf_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,   // sysex_chunk_len
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] midi_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [1:0] byte_count, [9:2] first_byte,
                                       // [17:10] second_byte, [25:18] third_byte,
                                       // [26] was_truncated, [31:27] zero
    output logic [1:0]  m_tuser,       // [1:0] result_kind
    output logic        m_tlast        // last_of_run
);

    logic              in_accept;
    logic              cmd_valid;
    mbf_pkg::cmd_t     cmd;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    mbf_pkg::cmd_t     q_data;
    mbf_pkg::result_t  out_res;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    mbf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (in_accept),
        .in_byte     (s_tdata),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd)
    );

    mbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_valid),
        .push_data (cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    mbf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .out_last  (m_tlast)
    );

    // Pack the result word
    assign m_tdata = {5'd0, out_res.trunc, out_res.byte2, out_res.byte1,
                      out_res.byte0, out_res.count};
    assign m_tuser = out_res.kind;

endmodule
